FILE: rtl/ctks_pkg.sv
// Shared types, token codes and character helpers of the token scanner.
package ctks_pkg;

  localparam int MAX_TEXT  = 256;
  localparam int POS_BITS  = 16;
  localparam int TEXT_W    = 9;
  localparam int VAL_W     = 63;
  localparam int FIFO_DEPTH = 4;

  localparam logic [VAL_W-1:0]    VAL_MAX = {VAL_W{1'b1}};
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  typedef logic [5:0] kind_t;

  localparam kind_t K_PLUS = 6'd0,  K_PLUS_PLUS = 6'd1, K_PLUS_EQ = 6'd2;
  localparam kind_t K_MINUS = 6'd3, K_MINUS_MINUS = 6'd4, K_MINUS_EQ = 6'd5;
  localparam kind_t K_ARROW = 6'd6, K_STAR = 6'd7, K_SLASH = 6'd9, K_MOD = 6'd11;
  localparam kind_t K_AND = 6'd13, K_AND_AND = 6'd14, K_AND_EQ = 6'd15;
  localparam kind_t K_PIPE = 6'd16, K_PIPE_PIPE = 6'd17, K_PIPE_EQ = 6'd18;
  localparam kind_t K_CARET = 6'd19, K_GT = 6'd21, K_SHR = 6'd22, K_SHR_EQ = 6'd23;
  localparam kind_t K_GT_EQ = 6'd24, K_LT = 6'd25, K_SHL = 6'd26, K_SHL_EQ = 6'd27;
  localparam kind_t K_LT_EQ = 6'd28, K_ASSIGN = 6'd29, K_DOT = 6'd31, K_DOT_DOT = 6'd32;
  localparam kind_t K_QUESTION = 6'd33, K_COLON = 6'd34, K_LPAREN = 6'd35;
  localparam kind_t K_RPAREN = 6'd36, K_LBRACKET = 6'd37, K_RBRACKET = 6'd38;
  localparam kind_t K_LBRACE = 6'd39, K_RBRACE = 6'd40, K_SEMI = 6'd41;
  localparam kind_t K_INT = 6'd42, K_DEC = 6'd43, K_CHAR = 6'd44, K_STRING = 6'd45;
  localparam kind_t K_KEYWORD = 6'd46, K_IDENT = 6'd47, K_EOF = 6'd48, K_ERROR = 6'd49;

  typedef logic [2:0] err_t;
  localparam err_t E_NONE = 3'd0, E_ESC_DIGIT = 3'd1, E_OPEN_CHAR = 3'd2;
  localparam err_t E_OPEN_STRING = 3'd3, E_SYMBOL = 3'd4, E_ESC_UNKNOWN = 3'd5;
  localparam err_t E_OVERFLOW = 3'd6;

  typedef enum logic [11:0] {
    M_IDLE     = 12'b000000000001,
    M_IDENT    = 12'b000000000010,
    M_INT      = 12'b000000000100,
    M_FRAC     = 12'b000000001000,
    M_OP1      = 12'b000000010000,
    M_OP2      = 12'b000000100000,
    M_STR      = 12'b000001000000,
    M_CH_START = 12'b000010000000,
    M_CH_ESC   = 12'b000100000000,
    M_CH_HEX   = 12'b001000000000,
    M_CH_OCT   = 12'b010000000000,
    M_CH_CLOSE = 12'b100000000000
  } mode_t;

  typedef struct packed {
    kind_t               kind;
    logic [1:0]          kwi;
    logic [VAL_W-1:0]    value;
    logic [7:0]          frac;
    logic [TEXT_W-1:0]   len;
    logic [POS_BITS-1:0] line;
    logic [POS_BITS-1:0] col;
    err_t                err;
    logic                txt;
    logic                last;
  } result_t;

  typedef struct packed {
    logic  hit;
    logic  shift;
    kind_t kind;
  } op_t;

  typedef struct packed {
    logic              ovf;
    logic [TEXT_W-1:0] tc;
    logic [3:0]        kc;
  } text_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] val;
  } hex_t;

  localparam logic [7:0] KW_TEXT [4][6] = '{
    '{"c", "l", "a", "s", "s", 8'h00},
    '{"s", "t", "r", "u", "c", "t"},
    '{"e", "n", "u", "m", 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n"}
  };

  function automatic logic [TEXT_W-1:0] kw_len(input logic [1:0] i);
    logic [TEXT_W-1:0] n;
    case (i)
      2'd0:    n = TEXT_W'(5);
      2'd2:    n = TEXT_W'(4);
      default: n = TEXT_W'(6);
    endcase
    return n;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.hit = 1'b0;
    h.val = b[3:0];
    if (is_digit(b)) begin
      h.hit = 1'b1;
    end else if (((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"))) begin
      h.hit = 1'b1;
      h.val = b[3:0] + 4'd9;
    end
    return h;
  endfunction

  function automatic op_t single_kind(input logic [7:0] p);
    op_t o;
    o.hit   = 1'b1;
    o.shift = 1'b0;
    unique case (p)
      "+":     o.kind = K_PLUS;
      "-":     o.kind = K_MINUS;
      "*":     o.kind = K_STAR;
      "/":     o.kind = K_SLASH;
      "%":     o.kind = K_MOD;
      "&":     o.kind = K_AND;
      "|":     o.kind = K_PIPE;
      "^":     o.kind = K_CARET;
      ">":     o.kind = K_GT;
      "<":     o.kind = K_LT;
      "=":     o.kind = K_ASSIGN;
      ".":     o.kind = K_DOT;
      default: begin
        o.hit  = 1'b0;
        o.kind = K_PLUS;
      end
    endcase
    return o;
  endfunction

  // Two-character operators; shift marks a '>>' or '<<' that may still take '='.
  function automatic op_t pair_kind(input logic [7:0] p, input logic [7:0] b);
    op_t o;
    o.hit   = 1'b0;
    o.shift = 1'b0;
    o.kind  = K_PLUS;
    unique case (p)
      "+": begin
        if (b == "+") begin o.hit = 1'b1; o.kind = K_PLUS_PLUS; end
        else if (b == "=") begin o.hit = 1'b1; o.kind = K_PLUS_EQ; end
      end
      "-": begin
        if (b == "-") begin o.hit = 1'b1; o.kind = K_MINUS_MINUS; end
        else if (b == "=") begin o.hit = 1'b1; o.kind = K_MINUS_EQ; end
        else if (b == ">") begin o.hit = 1'b1; o.kind = K_ARROW; end
      end
      "*", "/", "%", "^", "=": begin
        if (b == "=") begin o.hit = 1'b1; o.kind = single_kind(p).kind + 6'd1; end
      end
      "&": begin
        if (b == "&") begin o.hit = 1'b1; o.kind = K_AND_AND; end
        else if (b == "=") begin o.hit = 1'b1; o.kind = K_AND_EQ; end
      end
      "|": begin
        if (b == "|") begin o.hit = 1'b1; o.kind = K_PIPE_PIPE; end
        else if (b == "=") begin o.hit = 1'b1; o.kind = K_PIPE_EQ; end
      end
      ">": begin
        if (b == ">") o.shift = 1'b1;
        else if (b == "=") begin o.hit = 1'b1; o.kind = K_GT_EQ; end
      end
      "<": begin
        if (b == "<") o.shift = 1'b1;
        else if (b == "=") begin o.hit = 1'b1; o.kind = K_LT_EQ; end
      end
      ".": begin
        if (b == ".") begin o.hit = 1'b1; o.kind = K_DOT_DOT; end
      end
      default: o.hit = 1'b0;
    endcase
    return o;
  endfunction

  // Appends one text byte; for identifiers it also narrows the keyword candidates.
  function automatic text_t text_add(input logic [TEXT_W-1:0] tc, input logic [3:0] kc,
                                     input logic [7:0] b, input logic ident);
    text_t t;
    t.ovf = 1'b0;
    t.tc  = tc;
    t.kc  = kc;
    if (tc >= TEXT_W'(MAX_TEXT)) begin
      t.ovf = 1'b1;
      t.kc  = 4'd0;
    end else begin
      if (ident) begin
        for (int i = 0; i < 4; i++) begin
          if (!((tc < kw_len(2'(i))) && (KW_TEXT[i][tc[2:0]] == b))) t.kc[i] = 1'b0;
        end
      end
      t.tc = tc + TEXT_W'(1);
    end
    return t;
  endfunction

  function automatic result_t mk(input kind_t k, input logic [1:0] kwi,
                                 input logic [VAL_W-1:0] v, input logic [7:0] f,
                                 input logic [TEXT_W-1:0] len, input err_t e,
                                 input logic t, input logic [POS_BITS-1:0] ln,
                                 input logic [POS_BITS-1:0] cl);
    result_t r;
    r.kind  = k;
    r.kwi   = kwi;
    r.value = v;
    r.frac  = f;
    r.len   = len;
    r.line  = ln;
    r.col   = cl;
    r.err   = e;
    r.txt   = t;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/ctks_scan.sv
// Scanner state and the per-byte token logic that produces up to two results.
module ctks_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            in_byte,
  input  logic                  in_end,
  output ctks_pkg::result_t     res0,
  output ctks_pkg::result_t     res1,
  output logic [1:0]            res_cnt
);

  ctks_pkg::mode_t               mode, mode_next;
  logic [7:0]                    pend, pend_next;
  logic [ctks_pkg::POS_BITS-1:0] line, col, line1, col1;
  logic [3:0]                    kc, kc_next;
  logic [ctks_pkg::TEXT_W-1:0]   tc, tc_next;
  logic [ctks_pkg::VAL_W-1:0]    acc, acc_next;
  logic [7:0]                    fc, fc_next;
  logic [7:0]                    ev, ev_next;
  logic [1:0]                    ed, ed_next;

  logic                          consumed, ra_v, rb_v;
  ctks_pkg::result_t             ra, rb;
  ctks_pkg::text_t               ta;
  ctks_pkg::op_t                 op, sk;
  ctks_pkg::hex_t                hx;
  logic [ctks_pkg::VAL_W+3:0]    prod;
  logic                          sat;
  logic [1:0]                    kwi_sel;
  logic                          kw_hit;

  // Position after consuming the byte.
  always_comb begin
    line1 = line;
    col1  = col;
    if (in_byte == 8'h0A) begin
      if (line != ctks_pkg::POS_MAX) line1 = line + 1'b1;
      col1 = ctks_pkg::POS_BITS'(1);
    end else if (col != ctks_pkg::POS_MAX) begin
      col1 = col + 1'b1;
    end
  end

  // Times ten plus digit; anything in the top four bits is past the limit.
  assign prod = {acc, 3'b000} + {2'b00, acc, 1'b0} + (ctks_pkg::VAL_W+4)'(in_byte[3:0]);
  assign sat  = |prod[ctks_pkg::VAL_W+3:ctks_pkg::VAL_W];
  assign op   = ctks_pkg::pair_kind(pend, in_byte);
  assign sk   = ctks_pkg::single_kind(pend);
  assign hx   = ctks_pkg::hex_digit(in_byte);

  // Lowest-numbered surviving keyword of matching length.
  always_comb begin
    kw_hit  = 1'b0;
    kwi_sel = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (kc[i] && (tc == ctks_pkg::kw_len(2'(i)))) begin
        kw_hit  = 1'b1;
        kwi_sel = 2'(i);
      end
    end
  end

  always_comb begin
    mode_next = mode;
    pend_next = pend;
    kc_next   = kc;
    tc_next   = tc;
    acc_next  = acc;
    fc_next   = fc;
    ev_next   = ev;
    ed_next   = ed;
    consumed  = 1'b0;
    ra_v      = 1'b0;
    rb_v      = 1'b0;
    ra        = '0;
    rb        = '0;
    ta        = ctks_pkg::text_add(tc, kc, in_byte, mode == ctks_pkg::M_IDENT);

    if (in_end) begin
      ra_v = 1'b1;
      unique case (mode)
        ctks_pkg::M_IDENT:
          ra = ctks_pkg::mk(kw_hit ? ctks_pkg::K_KEYWORD : ctks_pkg::K_IDENT, kwi_sel, '0,
                            '0, tc, ctks_pkg::E_NONE, 1'b0, line, col);
        ctks_pkg::M_INT:
          ra = ctks_pkg::mk(ctks_pkg::K_INT, '0, acc, '0, '0, ctks_pkg::E_NONE, 1'b0,
                            line, col);
        ctks_pkg::M_FRAC:
          ra = ctks_pkg::mk(ctks_pkg::K_DEC, '0, acc, fc, '0, ctks_pkg::E_NONE, 1'b0,
                            line, col);
        ctks_pkg::M_OP1:
          ra = ctks_pkg::mk(sk.kind, '0, '0, '0, '0, ctks_pkg::E_NONE, 1'b0, line, col);
        ctks_pkg::M_OP2:
          ra = ctks_pkg::mk((pend == ">") ? ctks_pkg::K_SHR : ctks_pkg::K_SHL, '0, '0, '0,
                            '0, ctks_pkg::E_NONE, 1'b0, line, col);
        ctks_pkg::M_STR:
          ra = ctks_pkg::mk(ctks_pkg::K_ERROR, '0, '0, '0, '0, ctks_pkg::E_OPEN_STRING,
                            1'b0, line, col);
        ctks_pkg::M_CH_START, ctks_pkg::M_CH_ESC, ctks_pkg::M_CH_HEX, ctks_pkg::M_CH_OCT,
        ctks_pkg::M_CH_CLOSE:
          ra = ctks_pkg::mk(ctks_pkg::K_ERROR, '0, '0, '0, '0, ctks_pkg::E_OPEN_CHAR,
                            1'b0, line, col);
        default: ra_v = 1'b0;
      endcase
      rb_v      = 1'b1;
      rb        = ctks_pkg::mk(ctks_pkg::K_EOF, '0, '0, '0, '0, ctks_pkg::E_NONE, 1'b0,
                               line, col);
      mode_next = ctks_pkg::M_IDLE;
      pend_next = 8'd0;
    end else begin
      unique case (mode)
        ctks_pkg::M_IDENT: begin
          if (ctks_pkg::is_alpha(in_byte) || ctks_pkg::is_digit(in_byte) ||
              (in_byte == "_")) begin
            consumed = 1'b1;
            ra_v     = 1'b1;
            kc_next  = ta.kc;
            tc_next  = ta.tc;
            ra = ta.ovf ?
                 ctks_pkg::mk(ctks_pkg::K_ERROR, '0, '0, '0, '0, ctks_pkg::E_OVERFLOW, 1'b0,
                              line1, col1) :
                 ctks_pkg::mk(ctks_pkg::K_IDENT, '0, ctks_pkg::VAL_W'(in_byte), '0, ta.tc,
                              ctks_pkg::E_NONE, 1'b1, line1, col1);
          end else begin
            ra_v = 1'b1;
            ra = ctks_pkg::mk(kw_hit ? ctks_pkg::K_KEYWORD : ctks_pkg::K_IDENT, kwi_sel, '0,
                              '0, tc, ctks_pkg::E_NONE, 1'b0, line, col);
          end
        end
        ctks_pkg::M_INT: begin
          if (ctks_pkg::is_digit(in_byte)) begin
            consumed = 1'b1;
            acc_next = sat ? ctks_pkg::VAL_MAX : prod[ctks_pkg::VAL_W-1:0];
          end else if (in_byte == ".") begin
            consumed  = 1'b1;
            mode_next = ctks_pkg::M_FRAC;
            fc_next   = 8'd0;
          end else begin
            ra_v = 1'b1;
            ra = ctks_pkg::mk(ctks_pkg::K_INT, '0, acc, '0, '0, ctks_pkg::E_NONE, 1'b0,
                              line, col);
          end
        end
        ctks_pkg::M_FRAC: begin
          if (ctks_pkg::is_digit(in_byte)) begin
            consumed = 1'b1;
            if ((fc != 8'hFF) && !sat) begin
              acc_next = prod[ctks_pkg::VAL_W-1:0];
              fc_next  = fc + 8'd1;
            end
          end else begin
            ra_v = 1'b1;
            ra = ctks_pkg::mk(ctks_pkg::K_DEC, '0, acc, fc, '0, ctks_pkg::E_NONE, 1'b0,
                              line, col);
          end
        end
        ctks_pkg::M_OP1: begin
          if (op.shift) begin
            consumed  = 1'b1;
            mode_next = ctks_pkg::M_OP2;
          end else if (op.hit) begin
            consumed  = 1'b1;
            ra_v      = 1'b1;
            ra = ctks_pkg::mk(op.kind, '0, '0, '0, '0, ctks_pkg::E_NONE, 1'b0, line1, col1);
            mode_next = ctks_pkg::M_IDLE;
            pend_next = 8'd0;
          end else begin
            ra_v = 1'b1;
            ra = ctks_pkg::mk(sk.kind, '0, '0, '0, '0, ctks_pkg::E_NONE, 1'b0, line, col);
          end
        end
        ctks_pkg::M_OP2: begin
          ra_v = 1'b1;
          if (in_byte == "=") begin
            consumed  = 1'b1;
            ra = ctks_pkg::mk((pend == ">") ? ctks_pkg::K_SHR_EQ : ctks_pkg::K_SHL_EQ, '0,
                              '0, '0, '0, ctks_pkg::E_NONE, 1'b0, line1, col1);
            mode_next = ctks_pkg::M_IDLE;
            pend_next = 8'd0;
          end else begin
            ra = ctks_pkg::mk((pend == ">") ? ctks_pkg::K_SHR : ctks_pkg::K_SHL, '0, '0,
                              '0, '0, ctks_pkg::E_NONE, 1'b0, line, col);
          end
        end
        ctks_pkg::M_STR: begin
          consumed = 1'b1;
          ra_v     = 1'b1;
          if (in_byte == "\"") begin
            ra = ctks_pkg::mk(ctks_pkg::K_STRING, '0, '0, '0, tc, ctks_pkg::E_NONE, 1'b0,
                              line1, col1);
            mode_next = ctks_pkg::M_IDLE;
            pend_next = 8'd0;
          end else begin
            kc_next = ta.kc;
            tc_next = ta.tc;
            ra = ta.ovf ?
                 ctks_pkg::mk(ctks_pkg::K_ERROR, '0, '0, '0, '0, ctks_pkg::E_OVERFLOW, 1'b0,
                              line1, col1) :
                 ctks_pkg::mk(ctks_pkg::K_STRING, '0, ctks_pkg::VAL_W'(in_byte), '0, ta.tc,
                              ctks_pkg::E_NONE, 1'b1, line1, col1);
          end
        end
        ctks_pkg::M_CH_START: begin
          consumed = 1'b1;
          if (in_byte == "\\") begin
            mode_next = ctks_pkg::M_CH_ESC;
          end else begin
            ev_next   = in_byte;
            mode_next = ctks_pkg::M_CH_CLOSE;
          end
        end
        ctks_pkg::M_CH_ESC: begin
          consumed  = 1'b1;
          mode_next = ctks_pkg::M_CH_CLOSE;
          case (in_byte)
            "a": ev_next = 8'd7;
            "b": ev_next = 8'd8;
            "f": ev_next = 8'd12;
            "n": ev_next = 8'd10;
            "r": ev_next = 8'd13;
            "t": ev_next = 8'd9;
            "v": ev_next = 8'd11;
            "'", "\"", "\\": ev_next = in_byte;
            "x": begin
              ev_next   = 8'd0;
              ed_next   = 2'd0;
              mode_next = ctks_pkg::M_CH_HEX;
            end
            default: begin
              if ((in_byte >= "0") && (in_byte <= "7")) begin
                ev_next   = {5'd0, in_byte[2:0]};
                ed_next   = 2'd1;
                mode_next = ctks_pkg::M_CH_OCT;
              end else begin
                ra_v = 1'b1;
                ra = ctks_pkg::mk(ctks_pkg::K_ERROR, '0, '0, '0, '0,
                                  ctks_pkg::E_ESC_UNKNOWN, 1'b0, line1, col1);
                mode_next = ctks_pkg::M_IDLE;
                pend_next = 8'd0;
              end
            end
          endcase
        end
        ctks_pkg::M_CH_HEX: begin
          if (!hx.hit) begin
            ra_v = 1'b1;
            ra = ctks_pkg::mk(ctks_pkg::K_ERROR, '0, '0, '0, '0, ctks_pkg::E_ESC_DIGIT,
                              1'b0, line, col);
          end else begin
            consumed = 1'b1;
            ev_next  = {ev[3:0], hx.val};
            ed_next  = ed + 2'd1;
            if (ed == 2'd1) mode_next = ctks_pkg::M_CH_CLOSE;
          end
        end
        ctks_pkg::M_CH_OCT: begin
          if (!((in_byte >= "0") && (in_byte <= "7"))) begin
            ra_v = 1'b1;
            ra = ctks_pkg::mk(ctks_pkg::K_ERROR, '0, '0, '0, '0, ctks_pkg::E_ESC_DIGIT,
                              1'b0, line, col);
          end else begin
            consumed = 1'b1;
            ev_next  = {ev[4:0], in_byte[2:0]};
            ed_next  = ed + 2'd1;
            if (ed == 2'd2) mode_next = ctks_pkg::M_CH_CLOSE;
          end
        end
        ctks_pkg::M_CH_CLOSE: begin
          ra_v = 1'b1;
          if (in_byte == "'") begin
            consumed  = 1'b1;
            ra = ctks_pkg::mk(ctks_pkg::K_CHAR, '0, ctks_pkg::VAL_W'(ev), '0, '0,
                              ctks_pkg::E_NONE, 1'b0, line1, col1);
            mode_next = ctks_pkg::M_IDLE;
            pend_next = 8'd0;
          end else begin
            ra = ctks_pkg::mk(ctks_pkg::K_ERROR, '0, '0, '0, '0, ctks_pkg::E_OPEN_CHAR,
                              1'b0, line, col);
          end
        end
        default: consumed = 1'b0;
      endcase

      // A byte the open token did not take starts afresh from the idle state.
      if (!consumed) begin
        mode_next = ctks_pkg::M_IDLE;
        pend_next = 8'd0;
        ta = ctks_pkg::text_add('0, 4'hF, in_byte, 1'b1);
        if (ctks_pkg::is_alpha(in_byte)) begin
          mode_next = ctks_pkg::M_IDENT;
          kc_next   = ta.kc;
          tc_next   = ta.tc;
          rb_v      = 1'b1;
          rb = ctks_pkg::mk(ctks_pkg::K_IDENT, '0, ctks_pkg::VAL_W'(in_byte), '0, ta.tc,
                            ctks_pkg::E_NONE, 1'b1, line1, col1);
        end else if (ctks_pkg::is_digit(in_byte)) begin
          mode_next = ctks_pkg::M_INT;
          acc_next  = ctks_pkg::VAL_W'(in_byte[3:0]);
          fc_next   = 8'd0;
        end else if (in_byte == "\"") begin
          mode_next = ctks_pkg::M_STR;
          tc_next   = '0;
        end else if (in_byte == "'") begin
          mode_next = ctks_pkg::M_CH_START;
          ev_next   = 8'd0;
          ed_next   = 2'd0;
        end else if (ctks_pkg::single_kind(in_byte).hit) begin
          mode_next = ctks_pkg::M_OP1;
          pend_next = in_byte;
        end else begin
          rb_v = 1'b1;
          rb = ctks_pkg::mk(ctks_pkg::K_ERROR, '0, ctks_pkg::VAL_W'(in_byte), '0, '0,
                            ctks_pkg::E_SYMBOL, 1'b0, line1, col1);
          case (in_byte)
            "?": rb.kind = ctks_pkg::K_QUESTION;
            ":": rb.kind = ctks_pkg::K_COLON;
            "(": rb.kind = ctks_pkg::K_LPAREN;
            ")": rb.kind = ctks_pkg::K_RPAREN;
            "[": rb.kind = ctks_pkg::K_LBRACKET;
            "]": rb.kind = ctks_pkg::K_RBRACKET;
            "{": rb.kind = ctks_pkg::K_LBRACE;
            "}": rb.kind = ctks_pkg::K_RBRACE;
            ";": rb.kind = ctks_pkg::K_SEMI;
            " ", 8'h09, 8'h0A: rb_v = 1'b0;
            default: rb.kind = ctks_pkg::K_ERROR;
          endcase
          if (rb.kind != ctks_pkg::K_ERROR) begin
            rb.value = '0;
            rb.err   = ctks_pkg::E_NONE;
          end
        end
      end
    end
  end

  // Results in order, with the final one of this byte marked.
  always_comb begin
    res0    = ra_v ? ra : rb;
    res1    = rb;
    res_cnt = 2'(ra_v) + 2'(rb_v);
    if (res_cnt == 2'd1) res0.last = 1'b1;
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ctks_pkg::M_IDLE;
      pend <= 8'd0;
      line <= ctks_pkg::POS_BITS'(1);
      col  <= ctks_pkg::POS_BITS'(1);
      kc   <= 4'hF;
      tc   <= '0;
      acc  <= '0;
      fc   <= 8'd0;
      ev   <= 8'd0;
      ed   <= 2'd0;
    end else if (take) begin
      mode <= mode_next;
      pend <= pend_next;
      if (!in_end) begin
        line <= line1;
        col  <= col1;
      end
      kc   <= kc_next;
      tc   <= tc_next;
      acc  <= acc_next;
      fc   <= fc_next;
      ev   <= ev_next;
      ed   <= ed_next;
    end
  end

endmodule

FILE: rtl/ctks_fifo.sv
// Result queue that takes up to two results a cycle and gives one a cycle while pop is high.
module ctks_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  ctks_pkg::result_t din0,
  input  ctks_pkg::result_t din1,
  output logic              room,
  output ctks_pkg::result_t dout,
  output logic              dvalid,
  input  logic              pop
);

  localparam int AW = $clog2(ctks_pkg::FIFO_DEPTH);

  ctks_pkg::result_t mem [ctks_pkg::FIFO_DEPTH];
  logic [AW-1:0]     wp, rp;
  logic [AW:0]       count;
  logic              do_pop;

  assign dvalid = (count != '0);
  assign do_pop = pop && dvalid;
  assign room   = (count <= (AW+1)'(ctks_pkg::FIFO_DEPTH - 2));
  assign dout   = mem[rp];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wp] <= din0;
    if (push_n == 2'd2) mem[wp + AW'(1)] <= din1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + AW'(push_n);
      if (do_pop) rp <= rp + AW'(1);
      count <= count + (AW+1)'(push_n) - (AW+1)'(do_pop);
    end
  end

endmodule

FILE: rtl/c_like_token_scanner_core.sv
// Top level of the C-like token scanner: byte stream in, token stream out.
// Throughput: one byte per cycle while the four-entry result queue has two
// entries free, since it accepts a byte only then; a byte's results are
// registered in the queue, and bytes that make two results drain at one result
// per cycle on the output side while m_axis_tready is high.
// Reset (rst, synchronous, active high) empties the queue and returns the scanner
// to idle at line 1, column 1.
module c_like_token_scanner_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] src_byte
  input  logic         s_axis_tlast,  // end_of_input
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [5:0] token_kind, [7:6] keyword_index, [70:8] token_value,
  // [78:71] fraction_digits, [87:79] text_length, [103:88] line_number,
  // [119:104] column_number, [122:120] error_code, [127:123] zero
  output logic [127:0] m_axis_tdata,
  output logic         m_axis_tuser,  // is_text_byte
  output logic         m_axis_tlast   // last result caused by an input transaction
);

  logic              take;
  logic [1:0]        res_cnt;
  ctks_pkg::result_t res0, res1, head;
  logic              room;

  // A transaction is taken only while the queue can absorb the two results
  // it may cause, so the scanner never has to stall mid-byte.
  assign s_axis_tready = room;
  assign take          = s_axis_tvalid && s_axis_tready;

  ctks_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (s_axis_tdata),
    .in_end  (s_axis_tlast),
    .res0    (res0),
    .res1    (res1),
    .res_cnt (res_cnt)
  );

  // The queue separates the output handshake from the scanner.
  ctks_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push_n (take ? res_cnt : 2'd0),
    .din0   (res0),
    .din1   (res1),
    .room   (room),
    .dout   (head),
    .dvalid (m_axis_tvalid),
    .pop    (m_axis_tready)
  );

  assign m_axis_tdata = {5'd0, head.err, head.col, head.line, head.len, head.frac,
                         head.value, head.kwi, head.kind};
  assign m_axis_tuser = head.txt;
  assign m_axis_tlast = head.last;

endmodule

FILE: rtl/ctks_checker.sv
// Port-level checks of the token scanner and their attachment to the top level.
module ctks_port_checks (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  // A stalled result holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result offered after reset");

  // A text echo is only ever part of an identifier or a string.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[5:0] == ctks_pkg::K_STRING || m_axis_tdata[5:0] == ctks_pkg::K_IDENT)
    else $error("echo with wrong token kind");

  // An error code only comes with the error kind.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[122:120] != ctks_pkg::E_NONE |->
      m_axis_tdata[5:0] == ctks_pkg::K_ERROR)
    else $error("error code outside error token");

  // Positions are never zero.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[103:88] != 16'd0 && m_axis_tdata[119:104] != 16'd0)
    else $error("zero line or column");

endmodule

bind c_like_token_scanner_core ctks_port_checks u_ctks_port_checks (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
